@@ hw/rtl/jss_pkg.sv @@
// Shared types and constants for the Jacobi stencil sweep unit.
`timescale 1ns / 1ps

package jss_pkg;

  // Sample and field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned SideW   = 10;
  localparam int unsigned Lines   = 4;
  localparam int unsigned Win     = 5;
  localparam int unsigned Border  = 2;
  localparam int unsigned Margin  = 2 * Border;

  // Sum widths: one window row, four neighbors, full ring
  localparam int unsigned RowSumW = 19;
  localparam int unsigned Nb4W    = 18;
  localparam int unsigned RingW   = 21;

  // Reciprocal of 3 scaled by 2^19, exact for dividends below 2^19
  localparam int unsigned RecipW     = 18;
  localparam int unsigned RecipShift = 19;
  localparam logic [RecipW-1:0] Recip3 = 18'h2AAAB;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_STENCIL_MODE = 1'b0,
    CFG_GRID_SIDE    = 1'b1
  } jss_cfg_idx_e;

  localparam logic [SideW-1:0] GridSideReset = 10'd1020;

  typedef logic [SampleW-1:0] jss_sample_t;

  // One line store word: entry 0 is the oldest row
  typedef logic [Lines-1:0][SampleW-1:0] jss_line_t;

  // One window column: entry 0 is the top row
  typedef logic [Win-1:0][SampleW-1:0] jss_column_t;

  // Partial sums handed from the window to the reduction
  typedef struct packed {
    logic [Win-1:0][RowSumW-1:0] row;
    logic [Nb4W-1:0]             nb4;
  } jss_sums_t;

  // Result position and end marker carried alongside each item
  typedef struct packed {
    logic [SideW-1:0] row;
    logic [SideW-1:0] col;
    logic             last;
  } jss_tag_t;

endpackage

@@ hw/rtl/jss_line_store.sv @@
// Four-row line store: one column word per address, read-modify-write with forwarding.
`timescale 1ns / 1ps

module jss_line_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  jss_pkg::jss_line_t wr_data_i,
  output jss_pkg::jss_line_t rd_data_o
);

  jss_pkg::jss_line_t mem [Depth];
  jss_pkg::jss_line_t rd_q;
  jss_pkg::jss_line_t fwd_data_q;
  logic               fwd_q;

  // Write back and read one column word per cycle when enabled
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Catch a read that collides with the write of the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i && wr_en_i && (wr_addr_i == rd_addr_i)) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

@@ hw/rtl/jss_window.sv @@
// 5x5 sample window with registered row sums.
`timescale 1ns / 1ps

module jss_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                advance_i,
  input  jss_pkg::jss_column_t column_i,
  output jss_pkg::jss_sums_t   sums_o
);

  logic [jss_pkg::Win-1:0][jss_pkg::Win-1:0][jss_pkg::SampleW-1:0] win_q;
  jss_pkg::jss_sums_t sums_d;
  jss_pkg::jss_sums_t sums_q;

  // Shift every row left and insert the new column at the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      for (int r = 0; r < jss_pkg::Win; r++) begin
        for (int c = 0; c < jss_pkg::Win - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
        win_q[r][jss_pkg::Win-1] <= column_i[r];
      end
    end
  end

  // Sum each row, leaving out the center sample, and sum the four neighbors of the center
  always_comb begin
    sums_d = '0;
    for (int r = 0; r < jss_pkg::Win; r++) begin
      for (int c = 0; c < jss_pkg::Win; c++) begin
        if (!(r == jss_pkg::Border && c == jss_pkg::Border)) begin
          sums_d.row[r] = sums_d.row[r]
                        + jss_pkg::RowSumW'(win_q[r][c]);
        end
      end
    end
    sums_d.nb4 = jss_pkg::Nb4W'(win_q[1][2]) + jss_pkg::Nb4W'(win_q[3][2])
               + jss_pkg::Nb4W'(win_q[2][1]) + jss_pkg::Nb4W'(win_q[2][3]);
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

@@ hw/rtl/jss_reduce.sv @@
// Ring total and average: four-neighbor mean or ring sum divided by 24.
`timescale 1ns / 1ps

module jss_reduce (
  input  logic               clk_i,
  input  logic               advance_i,
  input  logic               mode_i,
  input  jss_pkg::jss_sums_t  sums_i,
  output jss_pkg::jss_sample_t value_o
);

  logic [jss_pkg::RingW-1:0]   ring_d;
  logic [jss_pkg::RingW-1:0]   ring_q;
  logic [jss_pkg::Nb4W-1:0]    nb4_q;
  logic [jss_pkg::RecipW-1:0]  eighth;
  logic [2*jss_pkg::RecipW-1:0] prod;
  jss_pkg::jss_sample_t         value_d;
  jss_pkg::jss_sample_t         value_q;

  // Add the five row sums
  always_comb begin
    ring_d = '0;
    for (int r = 0; r < jss_pkg::Win; r++) begin
      ring_d = ring_d + jss_pkg::RingW'(sums_i.row[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      ring_q <= ring_d;
      nb4_q  <= sums_i.nb4;
    end
  end

  // Divide by 24 as a shift by 3 and a reciprocal multiply by 3
  assign eighth = ring_q[jss_pkg::RingW-1:3];
  assign prod   = eighth * jss_pkg::Recip3;

  always_comb begin
    if (mode_i) begin
      value_d = prod[jss_pkg::RecipShift +: jss_pkg::SampleW];
    end else begin
      value_d = nb4_q[2 +: jss_pkg::SampleW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

@@ hw/rtl/jacobi_stencil_sweep_unit.sv @@
// Top level of the Jacobi stencil sweep unit.
// Takes one padded grid sample per cycle in raster order (row length grid_side + 4) and
// emits one updated point per cycle once the 5x5 window is centered on it; a result
// passes the first stage, window, row sums, ring total and output register. The rate
// is set by the line store, which reads and writes back one four-row column word per
// cycle, with forwarding when consecutive samples hit the same column. The pipeline
// advances as a whole whenever the output register is empty or being taken, so input
// stall follows output stall. The line store is not cleared after reset, and results
// from padded rows 2 and 3 read line store rows written before the grid began.
`timescale 1ns / 1ps

module jacobi_stencil_sweep_unit #(
  parameter int unsigned MAX_ROW = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  jss_pkg::jss_cfg_idx_e         cfg_idx_i,
  input  logic [jss_pkg::SideW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [jss_pkg::SampleW-1:0]   sample_i,
  input  logic                          first_of_grid_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [jss_pkg::SampleW-1:0]   new_value_o,
  output logic [jss_pkg::SideW-1:0]     out_row_o,
  output logic [jss_pkg::SideW-1:0]     out_col_o,
  output logic                          last_of_grid_o
);

  localparam int unsigned PosW = $clog2(MAX_ROW);
  localparam int unsigned CntW = ((PosW > jss_pkg::SideW) ? PosW : jss_pkg::SideW) + 1;
  localparam logic [CntW-1:0] MaxSide = CntW'(MAX_ROW - jss_pkg::Margin);
  localparam logic [CntW-1:0] MarginC = CntW'(jss_pkg::Margin);

  // Configuration registers
  logic                      mode_q;
  logic [jss_pkg::SideW-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      side_q <= jss_pkg::GridSideReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jss_pkg::CFG_STENCIL_MODE: mode_q <= cfg_data_i[0];
        jss_pkg::CFG_GRID_SIDE:    side_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic advance;
  logic in_xfer;
  logic out_valid_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;
  assign in_xfer    = in_valid_i && advance;

  // Position counters
  logic [PosW-1:0] row_pos_q, row_pos_d;
  logic [PosW-1:0] col_pos_q, col_pos_d;
  logic [CntW-1:0] side_eff, pad_side, cur_row, cur_col, row_inc, col_inc;
  logic [CntW-1:0] orow, ocol;
  logic            restart, produce, last;

  always_comb begin
    side_eff = (CntW'(side_q) > MaxSide) ? MaxSide : CntW'(side_q);
    pad_side = side_eff + MarginC;
    restart  = first_of_grid_i || (CntW'(row_pos_q) >= pad_side)
            || (CntW'(col_pos_q) >= pad_side);
    cur_row  = restart ? '0 : CntW'(row_pos_q);
    cur_col  = restart ? '0 : CntW'(col_pos_q);
    row_inc  = cur_row + CntW'(1);
    col_inc  = cur_col + CntW'(1);
    produce  = (cur_row >= MarginC) && (cur_col >= MarginC);
    orow     = cur_row - MarginC;
    ocol     = cur_col - MarginC;
    last     = (side_eff != '0) && (orow == side_eff - CntW'(1))
            && (ocol == side_eff - CntW'(1));
    if (col_inc >= pad_side) begin
      col_pos_d = '0;
      row_pos_d = (row_inc >= pad_side) ? '0 : row_inc[PosW-1:0];
    end else begin
      col_pos_d = col_inc[PosW-1:0];
      row_pos_d = cur_row[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q <= '0;
      col_pos_q <= '0;
    end else if (in_xfer) begin
      row_pos_q <= row_pos_d;
      col_pos_q <= col_pos_d;
    end
  end

  // First stage: sample, column and result tag wait for the line store read
  logic                 s1_v_q, s1_prod_q;
  jss_pkg::jss_sample_t s1_sample_q;
  logic [PosW-1:0]      s1_col_q;
  jss_pkg::jss_tag_t    s1_tag_q, tag_d;

  assign tag_d.row  = orow[jss_pkg::SideW-1:0];
  assign tag_d.col  = ocol[jss_pkg::SideW-1:0];
  assign tag_d.last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_prod_q <= 1'b0;
    end else if (advance) begin
      s1_v_q    <= in_valid_i;
      s1_prod_q <= in_valid_i && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sample_q <= sample_i;
      s1_col_q    <= cur_col[PosW-1:0];
      s1_tag_q    <= tag_d;
    end
  end

  // Line store read-modify-write
  jss_pkg::jss_line_t   line_rd, line_wr;
  jss_pkg::jss_column_t column;
  logic                 s1_fire;

  assign s1_fire = s1_v_q && advance;

  always_comb begin
    for (int k = 0; k < jss_pkg::Lines - 1; k++) begin
      line_wr[k] = line_rd[k+1];
    end
    line_wr[jss_pkg::Lines-1] = s1_sample_q;
    for (int k = 0; k < jss_pkg::Lines; k++) begin
      column[k] = line_rd[k];
    end
    column[jss_pkg::Win-1] = s1_sample_q;
  end

  jss_line_store #(
    .Depth (MAX_ROW),
    .AddrW (PosW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (cur_col[PosW-1:0]),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i (line_wr),
    .rd_data_o (line_rd)
  );

  // Window and row sums
  jss_pkg::jss_sums_t sums;

  jss_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (s1_fire),
    .advance_i (advance),
    .column_i  (column),
    .sums_o    (sums)
  );

  // Reduction to the new value
  jss_pkg::jss_sample_t value;

  jss_reduce u_reduce (
    .clk_i     (clk_i),
    .advance_i (advance),
    .mode_i    (mode_q),
    .sums_i    (sums),
    .value_o   (value)
  );

  // Carry result valid and tag alongside the window, sum and total stages
  logic              s2_v_q, s3_v_q, s4_v_q;
  jss_pkg::jss_tag_t s2_tag_q, s3_tag_q, s4_tag_q, out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s2_v_q      <= s1_v_q && s1_prod_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      out_valid_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_tag_q  <= s1_tag_q;
      s3_tag_q  <= s2_tag_q;
      s4_tag_q  <= s3_tag_q;
      out_tag_q <= s4_tag_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_value_o    = value;
  assign out_row_o      = out_tag_q.row;
  assign out_col_o      = out_tag_q.col;
  assign last_of_grid_o = out_tag_q.last;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the Jacobi stencil sweep unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SampleW  = jss_pkg::SampleW;
  localparam int unsigned SideW    = jss_pkg::SideW;
  localparam int unsigned Lines    = jss_pkg::Lines;
  localparam int unsigned Win      = jss_pkg::Win;
  localparam int unsigned Margin   = jss_pkg::Margin;
  localparam int unsigned MaxRow   = 1024;
  localparam int unsigned MaxSide  = MaxRow - Margin;
  localparam int unsigned TailWait = 12;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               first;
  } grid_sample_t;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic [SideW-1:0]   row;
    logic [SideW-1:0]   col;
    logic               last;
  } stencil_point_t;

  // Clock, reset and block ports
  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  jss_pkg::jss_cfg_idx_e cfg_idx = jss_pkg::CFG_STENCIL_MODE;
  logic [SideW-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SampleW-1:0]    sample = '0;
  logic                  first_of_grid = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SampleW-1:0]    new_value;
  logic [SideW-1:0]      out_row;
  logic [SideW-1:0]      out_col;
  logic                  last_of_grid;

  // Stimulus and checking state
  grid_sample_t   sample_queue[$];
  stencil_point_t expected_points[$];
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    samples_sent = 0;
  int unsigned    points_checked = 0;
  int unsigned    settings_used = 0;
  int unsigned    fail_count = 0;

  // Predictor copy of the sweep state and registers
  logic [SampleW-1:0] line_store[Lines][MaxRow] = '{default: '0};
  logic [SampleW-1:0] win[Win][Win] = '{default: '0};
  int unsigned        pad_row = 0;
  int unsigned        pad_col = 0;
  logic               model_mode = 1'b0;
  logic [SideW-1:0]   model_side = jss_pkg::GridSideReset;

  jacobi_stencil_sweep_unit #(
    .MAX_ROW(MaxRow)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .first_of_grid_i(first_of_grid),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .new_value_o    (new_value),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .last_of_grid_o (last_of_grid)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advance the sweep by one padded sample; queue the updated point once the
  // padded row and column both reach the margin
  task automatic predict_stencil_point(input logic [SampleW-1:0] s, input logic first);
    int unsigned    n;
    int unsigned    p;
    int unsigned    row;
    int unsigned    col;
    int unsigned    ring_sum;
    int unsigned    cross_sum;
    logic [SampleW-1:0] column[Win];
    stencil_point_t pt;
    n = (model_side > MaxSide) ? MaxSide : model_side;
    p = n + Margin;
    if (first || pad_row >= p || pad_col >= p) begin
      pad_row = 0;
      pad_col = 0;
    end
    row = pad_row;
    col = pad_col;
    for (int k = 0; k < Lines; k++) column[k] = line_store[k][col];
    column[Lines] = s;
    for (int k = 0; k + 1 < Lines; k++) line_store[k][col] = line_store[k+1][col];
    line_store[Lines-1][col] = s;
    for (int r = 0; r < Win; r++) begin
      for (int k = 0; k + 1 < Win; k++) win[r][k] = win[r][k+1];
      win[r][Win-1] = column[r];
    end
    if (row >= Margin && col >= Margin) begin
      ring_sum = 0;
      for (int r = 0; r < Win; r++)
        for (int c = 0; c < Win; c++)
          if (!(r == 2 && c == 2)) ring_sum += win[r][c];
      cross_sum = win[1][2] + win[3][2] + win[2][1] + win[2][3];
      pt.value = model_mode ? SampleW'(ring_sum / 24) : SampleW'(cross_sum >> 2);
      pt.row   = SideW'(row - Margin);
      pt.col   = SideW'(col - Margin);
      pt.last  = (n != 0) && (row - Margin == n - 1) && (col - Margin == n - 1);
      expected_points.insert(expected_points.size(), pt);
    end
    if (col + 1 >= p) begin
      pad_col = 0;
      pad_row = (row + 1 >= p) ? 0 : row + 1;
    end else begin
      pad_col = col + 1;
    end
  endtask

  // Driver: account for the transfer just taken, then present the next sample
  always @(posedge clk_i or negedge rst_n) begin : sample_driver
    grid_sample_t nxt;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      sample        <= '0;
      first_of_grid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_stencil_point(sample, first_of_grid);
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = sample_queue.pop_front();
          in_valid      <= 1'b1;
          sample        <= nxt.sample;
          first_of_grid <= nxt.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expected point
  always @(posedge clk_i or negedge rst_n) begin : point_monitor
    stencil_point_t pt;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: row %0d col %0d value %0d", out_row, out_col, new_value);
          fail_count++;
        end else begin
          pt = expected_points.pop_front();
          points_checked++;
          if (new_value !== pt.value) begin
            $error("new_value: expected %0d, actual %0d", pt.value, new_value);
            fail_count++;
          end
          if (out_row !== pt.row) begin
            $error("out_row: expected %0d, actual %0d", pt.row, out_row);
            fail_count++;
          end
          if (out_col !== pt.col) begin
            $error("out_col: expected %0d, actual %0d", pt.col, out_col);
            fail_count++;
          end
          if (last_of_grid !== pt.last) begin
            $error("last_of_grid: expected %0d, actual %0d", pt.last, last_of_grid);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Write one register and mirror it into the predictor
  task automatic write_reg(input jss_pkg::jss_cfg_idx_e idx, input logic [SideW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      jss_pkg::CFG_STENCIL_MODE: model_mode = data[0];
      jss_pkg::CFG_GRID_SIDE:    model_side = data;
      default: ;
    endcase
  endtask

  // Hold until every queued sample is taken and every point has arrived,
  // then let in-flight samples that make no point drain out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid || expected_points.size() != 0);
    repeat (TailWait) @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] rand_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return SampleW'($urandom_range(32768));
    if (roll < 80) return '0;
    if (roll < 90) return SampleW'(32768);
    return SampleW'($urandom_range(65535));
  endfunction

  // Queue a run of samples; fixed_value below zero draws each sample at random
  task automatic push_run(input int unsigned count, input bit flag_first,
                          input int fixed_value);
    grid_sample_t it;
    for (int unsigned i = 0; i < count; i++) begin
      it.sample = (fixed_value < 0) ? rand_sample() : SampleW'(fixed_value);
      it.first  = flag_first && (i == 0);
      sample_queue.insert(sample_queue.size(), it);
    end
  endtask

  // One random register setting followed by a mix of grids, aborted grids
  // and noise
  task automatic run_random_segment(inout int unsigned phase_items);
    int unsigned  target;
    int unsigned  side;
    int unsigned  p;
    int unsigned  roll;
    int unsigned  len;
    int unsigned  done_items;
    grid_sample_t it;
    roll = $urandom_range(99);
    if (roll < 5) side = 0;
    else if (roll < 80) side = $urandom_range(1, 8);
    else side = $urandom_range(9, 12);
    p = side + Margin;
    write_reg(jss_pkg::CFG_STENCIL_MODE, SideW'($urandom_range(1)));
    write_reg(jss_pkg::CFG_GRID_SIDE, SideW'(side));
    settings_used++;
    target = $urandom_range(40, 120);
    done_items = 0;
    while (done_items < target) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        push_run(p * p, 1'b1, -1);
        done_items += p * p;
      end else if (roll < 82) begin
        // rely on the end-of-grid wrap instead of the start flag
        push_run(p * p, 1'b0, -1);
        done_items += p * p;
      end else if (roll < 94) begin
        len = $urandom_range(1, p * p - 1);
        push_run(len, 1'b1, -1);
        done_items += len;
      end else begin
        len = $urandom_range(1, 8);
        for (int unsigned i = 0; i < len; i++) begin
          it.sample = SampleW'($urandom_range(65535));
          it.first  = 1'($urandom_range(1));
          sample_queue.insert(sample_queue.size(), it);
        end
        done_items += len;
      end
    end
    wait_drained();
    phase_items += done_items;
  endtask

  // Main sequence
  initial begin : stimulus
    int unsigned phase_items;
    rst_n = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    send_idle_pct = 23;
    recv_idle_pct = 52;

    // Fill all four rows of every column that the later grids read for their points
    write_reg(jss_pkg::CFG_GRID_SIDE, SideW'(12));
    settings_used++;
    push_run(4 * 16, 1'b1, -1);
    wait_drained();

    // Oversized side saturates to the full line: one padded row and a bit more
    write_reg(jss_pkg::CFG_STENCIL_MODE, SideW'(0));
    write_reg(jss_pkg::CFG_GRID_SIDE, SideW'(1023));
    settings_used++;
    push_run(MaxRow + 6, 1'b1, -1);
    wait_drained();

    // Shrink the side mid-grid while the counters stay in range
    write_reg(jss_pkg::CFG_GRID_SIDE, SideW'(8));
    settings_used++;
    push_run(72, 1'b0, -1);
    wait_drained();

    // Switch to the ring average in the middle of a grid
    write_reg(jss_pkg::CFG_STENCIL_MODE, SideW'(1));
    settings_used++;
    push_run(72, 1'b0, -1);
    wait_drained();

    // Smallest grid, all samples at full scale, ring average
    write_reg(jss_pkg::CFG_GRID_SIDE, SideW'(1));
    settings_used++;
    push_run(25, 1'b1, 65535);
    wait_drained();

    // Next grid starts by wrap alone; cross average with a zero center
    write_reg(jss_pkg::CFG_STENCIL_MODE, SideW'(0));
    settings_used++;
    push_run(12, 1'b0, 65535);
    push_run(1, 1'b0, 0);
    push_run(12, 1'b0, 65535);
    wait_drained();

    // Zero side, with a run too short to reach a point
    write_reg(jss_pkg::CFG_GRID_SIDE, SideW'(0));
    settings_used++;
    push_run(6, 1'b1, -1);
    wait_drained();

    // Random part in three idling phases
    phase_items = 0;
    while (phase_items < 180) run_random_segment(phase_items);
    send_idle_pct = 52;
    recv_idle_pct = 23;
    phase_items = 0;
    while (phase_items < 180) run_random_segment(phase_items);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_items = 0;
    while (phase_items < 180) run_random_segment(phase_items);

    wait_drained();
    if (expected_points.size() != 0) begin
      $error("%0d expected points never arrived", expected_points.size());
      fail_count++;
    end
    $display("Run sent %0d samples and checked %0d points across %0d register settings,",
             samples_sent, points_checked, settings_used);
    $display("covering both stencil modes, sides from zero to saturated, wraps and restarts.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
